// ===== src/rsc_pkg.sv =====
// shared types and codes for the rpn stack calculator
package rsc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned DepthW = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = $clog2(DataW);

  localparam logic [FuncW-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FuncW-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DIV  = 3'd4;

  typedef enum logic [StatW-1:0] {
    STAT_OK,
    STAT_UNDER,
    STAT_OVER,
    STAT_DIVZERO
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_CALC,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

endpackage

// ===== src/rsc_if.sv =====
// request and response channel interfaces
interface rsc_req_if;
  logic                          valid;
  logic                          ready;
  logic [rsc_pkg::FuncW-1:0]     func;
  logic signed [rsc_pkg::DataW-1:0] operand_value;

  modport source (output valid, output func, output operand_value, input ready);
  modport sink   (input valid, input func, input operand_value, output ready);
endinterface

interface rsc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [rsc_pkg::DataW-1:0] top_value;
  logic [rsc_pkg::DepthW-1:0]       stack_depth;
  logic [rsc_pkg::StatW-1:0]        status;

  modport source (output valid, output top_value, output stack_depth, output status,
                  input ready);
  modport sink   (input valid, input top_value, input stack_depth, input status,
                  output ready);
endinterface

// ===== src/rpn_stack_calculator.sv =====
// rpn stack calculator top level: control, stack pointer and result register
//
// usage: each request on req_i carries func and operand_value. func push places
// operand_value on the stack, add/sub/mul/div combine the two top entries (the
// deeper one is the left operand) and leave the result on top. every request
// gives exactly one response on rsp_o: the new top value (0 if empty), the depth
// and a status (ok, underflow, overflow, divide by zero). a failing request
// leaves the stack as it was; unused func codes report ok and change nothing.
// a push, an unused code or a failing operator goes from decode straight to the
// finish state; an arithmetic operator passes through load and calc and waits
// for the bit-serial unit, which handles one bit of the 32-bit word per cycle.
// the next request is taken in the cycle after the response is written.
// one request is in work at a time; the next is taken once the current one
// has moved into the response register, so a new request overlaps a waiting
// response. if the receiver stalls, the response holds and the block stops
// before writing the next result. reset empties the stack (depth 0); stack
// contents themselves are not cleared.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsc_req_if.sink   req_i,
  rsc_rsp_if.source rsp_o
);

  localparam int unsigned W     = rsc_pkg::DataW;
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  rsc_pkg::state_e  state_q, state_d;
  rsc_pkg::status_e status_q, status_d;
  logic [rsc_pkg::FuncW-1:0] func_q;
  logic [W-1:0]     val_q, top_q, top_d;
  logic [SpW-1:0]   sp_q, sp_d, sp_m2;

  logic                        out_valid_q;
  logic [W-1:0]                out_top_q;
  logic [rsc_pkg::DepthW-1:0]  out_depth_q;
  rsc_pkg::status_e            out_status_q;
  logic [SpW+rsc_pkg::DepthW-1:0] depth_wide;

  logic accept, slot_free, commit, is_push, is_op, full, under, do_push, do_op;
  rsc_pkg::alu_ctl_t alu_ctl;
  logic         alu_done;
  logic [W-1:0] alu_res, ram_rdata, ram_wdata;
  logic         ram_we;
  logic [AddrW-1:0] ram_waddr;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign is_push   = func_q == rsc_pkg::FUNC_PUSH;
  assign is_op     = (func_q >= rsc_pkg::FUNC_ADD) && (func_q <= rsc_pkg::FUNC_DIV);
  assign full      = sp_q == SpW'(STACK_DEPTH);
  assign under     = sp_q < SpW'(2);
  assign sp_m2     = sp_q - SpW'(2);
  assign do_push   = is_push && (status_q == rsc_pkg::STAT_OK);
  assign do_op     = is_op && (status_q == rsc_pkg::STAT_OK);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsc_pkg::S_IDLE:   if (accept) state_d = rsc_pkg::S_DECODE;
      rsc_pkg::S_DECODE: begin
        if (is_op && !under && !(func_q == rsc_pkg::FUNC_DIV && top_q == '0)) begin
          state_d = rsc_pkg::S_LOAD;
        end else begin
          state_d = rsc_pkg::S_FINISH;
        end
      end
      rsc_pkg::S_LOAD:   state_d = rsc_pkg::S_CALC;
      rsc_pkg::S_CALC:   if (alu_done) state_d = rsc_pkg::S_FINISH;
      rsc_pkg::S_FINISH: if (slot_free) state_d = rsc_pkg::S_IDLE;
      default:           state_d = rsc_pkg::S_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    req_i.ready   = state_q == rsc_pkg::S_IDLE;
    alu_ctl.start = state_q == rsc_pkg::S_LOAD;
    commit        = (state_q == rsc_pkg::S_FINISH) && slot_free;
    unique case (func_q)
      rsc_pkg::FUNC_ADD: alu_ctl.op = rsc_pkg::ALU_ADD;
      rsc_pkg::FUNC_SUB: alu_ctl.op = rsc_pkg::ALU_SUB;
      rsc_pkg::FUNC_MUL: alu_ctl.op = rsc_pkg::ALU_MUL;
      default:           alu_ctl.op = rsc_pkg::ALU_DIV;
    endcase
  end

  // status decided once the request is latched
  always_comb begin
    status_d = rsc_pkg::STAT_OK;
    priority if (is_push && full) begin
      status_d = rsc_pkg::STAT_OVER;
    end else if (is_op && under) begin
      status_d = rsc_pkg::STAT_UNDER;
    end else if (is_op && func_q == rsc_pkg::FUNC_DIV && top_q == '0) begin
      status_d = rsc_pkg::STAT_DIVZERO;
    end else begin
      status_d = rsc_pkg::STAT_OK;
    end
  end

  // commit values
  always_comb begin
    ram_we    = commit && (do_push || do_op);
    ram_waddr = do_push ? sp_q[AddrW-1:0] : sp_m2[AddrW-1:0];
    ram_wdata = do_push ? val_q : alu_res;
    top_d     = top_q;
    sp_d      = sp_q;
    if (do_push) begin
      top_d = val_q;
      sp_d  = sp_q + SpW'(1);
    end else if (do_op) begin
      top_d = alu_res;
      sp_d  = sp_q - SpW'(1);
    end
    depth_wide = {{rsc_pkg::DepthW{1'b0}}, sp_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        sp_q        <= sp_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      val_q  <= req_i.operand_value;
    end
    if (state_q == rsc_pkg::S_DECODE) begin
      status_q <= status_d;
    end
    if (commit) begin
      top_q        <= top_d;
      out_top_q    <= (sp_d == '0) ? '0 : top_d;
      out_depth_q  <= depth_wide[rsc_pkg::DepthW-1:0];
      out_status_q <= status_q;
    end
  end

  rsc_ram #(
    .Width (W),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (sp_m2[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  rsc_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (alu_ctl),
    .lhs_i    (ram_rdata),
    .rhs_i    (top_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.top_value   = out_top_q;
  assign rsp_o.stack_depth = out_depth_q;
  assign rsp_o.status      = out_status_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_sp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q != $past(sp_q)) |-> (sp_q == $past(sp_q) + SpW'(1)) ||
                              (sp_q == $past(sp_q) - SpW'(1)))
    else $error("stack pointer moved by more than one");

  a_alu_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == rsc_pkg::S_CALC)
    else $error("alu finished outside calc state");

  a_fail_keeps_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_q != rsc_pkg::STAT_OK) |=> $stable(sp_q))
    else $error("failed request changed the stack");

  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_depth_q == '0 && sp_q == '0) |-> out_top_q == '0)
    else $error("empty stack reports nonzero top");

endmodule

// ===== src/rsc_ram.sv =====
// generic single write port ram with registered read
module rsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rsc_alu.sv =====
// bit-serial add/sub, shift-add multiply and restoring divide
module rsc_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rsc_pkg::alu_ctl_t         ctl_i,
  input  logic [rsc_pkg::DataW-1:0] lhs_i,
  input  logic [rsc_pkg::DataW-1:0] rhs_i,
  output logic                      done_o,
  output logic [rsc_pkg::DataW-1:0] result_o
);

  localparam int unsigned W = rsc_pkg::DataW;

  logic                      busy_q, fix_q, done_q;
  logic [rsc_pkg::CntW-1:0]  cnt_q;
  rsc_pkg::alu_op_e          op_q;
  logic                      neg_q, carry_q;
  logic [W-1:0]              x_q, y_q, z_q, res_q;

  logic         sum_bit, carry_out;
  logic [W-1:0] mul_sum, div_t, div_diff, sel, fixed;
  logic         div_ge;
  logic [W-1:0] lhs_mag, rhs_mag;

  always_comb begin
    sum_bit   = x_q[0] ^ y_q[0] ^ carry_q;
    carry_out = (x_q[0] & y_q[0]) | (x_q[0] & carry_q) | (y_q[0] & carry_q);
    mul_sum   = z_q + (y_q[0] ? x_q : '0);
    // remainder stays below the divisor, so its top bit is always clear
    div_t     = {z_q[W-2:0], y_q[W-1]};
    div_ge    = div_t >= x_q;
    div_diff  = div_t - x_q;
    sel       = (op_q == rsc_pkg::ALU_DIV) ? y_q : z_q;
    fixed     = neg_q ? (~sel + W'(1)) : sel;
    lhs_mag   = lhs_i[W-1] ? (~lhs_i + W'(1)) : lhs_i;
    rhs_mag   = rhs_i[W-1] ? (~rhs_i + W'(1)) : rhs_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + rsc_pkg::CntW'(1);
        if (cnt_q == rsc_pkg::CntW'(W - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q    <= ctl_i.op;
      neg_q   <= 1'b0;
      carry_q <= 1'b0;
      x_q     <= lhs_i;
      y_q     <= rhs_i;
      z_q     <= '0;
      unique case (ctl_i.op)
        rsc_pkg::ALU_ADD: ;
        rsc_pkg::ALU_SUB: begin
          y_q     <= ~rhs_i;
          carry_q <= 1'b1;
        end
        rsc_pkg::ALU_MUL: ;
        rsc_pkg::ALU_DIV: begin
          x_q   <= rhs_mag;
          y_q   <= lhs_mag;
          neg_q <= lhs_i[W-1] ^ rhs_i[W-1];
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        rsc_pkg::ALU_ADD, rsc_pkg::ALU_SUB: begin
          x_q     <= x_q >> 1;
          y_q     <= y_q >> 1;
          z_q     <= {sum_bit, z_q[W-1:1]};
          carry_q <= carry_out;
        end
        rsc_pkg::ALU_MUL: begin
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
          z_q <= mul_sum;
        end
        rsc_pkg::ALU_DIV: begin
          z_q <= div_ge ? div_diff : div_t;
          y_q <= {y_q[W-2:0], div_ge};
        end
      endcase
    end
    if (fix_q) begin
      res_q <= fixed;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
